[rtl/vertex_transform_perspective_divide_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform block
// Concurrent property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_MACROS_SVH

// Same-cycle implication, off while reset is high
`define VTPD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, always on
`define VTPD_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/vtpd_pkg.sv]
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared widths, latencies and stage types of the vertex transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

   localparam int VTPD_ELEM_W      = 32;
   localparam int VTPD_ACC_W       = 48;
   localparam int VTPD_NUM_PAIRS   = 8;
   localparam int VTPD_CSR_INDEX_W = 4;
   localparam int VTPD_CSR_DATA_W  = 64;
   localparam int VTPD_QUO_W       = 32;

   // column: product stage + sum/clamp stage
   localparam int VTPD_COL_LAT = 2;
   // divider: entry stage + one stage per quotient bit + output stage
   localparam int VTPD_DIV_LAT = VTPD_QUO_W + 2;
   localparam int VTPD_LATENCY = VTPD_COL_LAT + VTPD_DIV_LAT;

   localparam logic signed [VTPD_ELEM_W-1:0] VTPD_OUT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VTPD_ELEM_W-1:0] VTPD_OUT_MIN = 32'sh8000_0000;

   typedef logic signed [VTPD_ELEM_W-1:0] vtpd_elem_type;
   typedef logic signed [VTPD_ACC_W-1:0]  vtpd_acc_type;

   typedef struct packed {
      logic                  vld;
      logic [VTPD_ACC_W-1:0] rem;
      logic [VTPD_ACC_W-1:0] dvs;
      logic [VTPD_QUO_W-1:0] dnd;
      logic [VTPD_QUO_W-1:0] quo;
      logic                  neg;
      logic                  ovf;
      logic                  wz;
      logic                  npos;
      logic                  nneg;
   } vtpd_div_stage_type;

   typedef struct packed {
      logic acc_sat;
      logic wz;
   } vtpd_flag_type;

endpackage

`default_nettype wire

[rtl/vertex_transform_perspective_divide.sv]
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// 4x4 homogeneous vertex transform with perspective divide, Q16.16 default.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with req_x_in/req_y_in/req_z_in; a beat is taken at each
//   clock edge where start is high and busy is low. busy is high only while
//   reset is held, so one vertex can enter on every cycle.
//   Each beat yields exactly one result beat: rsp_valid is high for one
//   cycle with rsp_x_out/rsp_y_out/rsp_z_out, rsp_w_zero and rsp_saturated.
//   Beats pass the column multiply/accumulate (product, sum/clamp), then
//   the bit-per-stage divider (32 quotient bits); throughput is one vertex
//   per cycle while busy is low. Results leave in order of entry.
//   The matrix lives in eight 64-bit registers written through csr_we,
//   csr_index and csr_wdata; indexes above 7 are dropped. Write them only
//   while no vertex is in flight.
//   Reset loads the identity matrix and clears all valid bits; beats in
//   flight are dropped. The receiver cannot stall: results are not held.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_perspective_divide
   import vtpd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  vtpd_elem_type               req_x_in,
   input  vtpd_elem_type               req_y_in,
   input  vtpd_elem_type               req_z_in,
   output logic                        rsp_valid,
   output vtpd_elem_type               rsp_x_out,
   output vtpd_elem_type               rsp_y_out,
   output vtpd_elem_type               rsp_z_out,
   output logic                        rsp_w_zero,
   output logic                        rsp_saturated,
   input  logic                        csr_we,
   input  logic [VTPD_CSR_INDEX_W-1:0] csr_index,
   input  logic [VTPD_CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [VTPD_CSR_DATA_W-1:0] ONE_LO = 64'd1 << FRAC_BITS;
   localparam logic [VTPD_CSR_DATA_W-1:0] ONE_HI = ONE_LO << VTPD_ELEM_W;

   logic [VTPD_CSR_DATA_W-1:0] pair_ff [VTPD_NUM_PAIRS];
   logic                       accept;
   vtpd_elem_type              elem [4][4];
   vtpd_acc_type               h [4];
   logic [3:0]                 col_sat, col_vld;
   logic [2:0]                 div_sat;
   vtpd_elem_type              div_quo [3];
   logic [2:0]                 div_vld;
   vtpd_flag_type              flag_ff [VTPD_DIV_LAT];
   vtpd_flag_type              flag_in;

   // hold the pipeline only during reset
   assign busy   = reset;
   assign accept = start && !busy;

   // matrix registers: drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < VTPD_NUM_PAIRS; k++) begin
            pair_ff[k] <= '0;
         end
         pair_ff[0] <= ONE_LO;
         pair_ff[2] <= ONE_HI;
         pair_ff[5] <= ONE_LO;
         pair_ff[7] <= ONE_HI;
      end else if (csr_we && (csr_index < VTPD_CSR_INDEX_W'(VTPD_NUM_PAIRS))) begin
         pair_ff[csr_index[$clog2(VTPD_NUM_PAIRS)-1:0]] <= csr_wdata;
      end
   end

   // row r, column c: pair 2r + c/2, half c%2
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            elem[r][c] = (c % 2 == 1) ? pair_ff[2*r + c/2][2*VTPD_ELEM_W-1:VTPD_ELEM_W]
                                      : pair_ff[2*r + c/2][VTPD_ELEM_W-1:0];
         end
      end
   end

   for (genvar c = 0; c < 4; c++) begin : g_col
      vtpd_col #(.FRAC_BITS(FRAC_BITS)) u_col (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (accept),
         .x_in      (req_x_in),
         .y_in      (req_y_in),
         .z_in      (req_z_in),
         .m0        (elem[0][c]),
         .m1        (elem[1][c]),
         .m2        (elem[2][c]),
         .t         (elem[3][c]),
         .out_valid (col_vld[c]),
         .h         (h[c]),
         .sat       (col_sat[c])
      );
   end

   // divide x, y, z by w; the three dividers advance in lockstep
   vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock(clock), .reset(reset), .in_valid(col_vld[0]),
      .num(h[0]), .den(h[3]),
      .out_valid(div_vld[0]), .quo(div_quo[0]), .sat(div_sat[0])
   );
   vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock(clock), .reset(reset), .in_valid(col_vld[1]),
      .num(h[1]), .den(h[3]),
      .out_valid(div_vld[1]), .quo(div_quo[1]), .sat(div_sat[1])
   );
   vtpd_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
      .clock(clock), .reset(reset), .in_valid(col_vld[2]),
      .num(h[2]), .den(h[3]),
      .out_valid(div_vld[2]), .quo(div_quo[2]), .sat(div_sat[2])
   );

   // advance accumulator flags alongside the divider stages
   always_comb begin
      flag_in.acc_sat = |col_sat;
      flag_in.wz      = (h[3] == '0) && col_vld[3];
   end

   always_ff @(posedge clock) begin
      flag_ff[0] <= flag_in;
      for (int k = 1; k < VTPD_DIV_LAT; k++) begin
         flag_ff[k] <= flag_ff[k-1];
      end
   end

   assign rsp_valid     = &div_vld;
   assign rsp_x_out     = div_quo[0];
   assign rsp_y_out     = div_quo[1];
   assign rsp_z_out     = div_quo[2];
   assign rsp_w_zero    = flag_ff[VTPD_DIV_LAT-1].wz;
   assign rsp_saturated = flag_ff[VTPD_DIV_LAT-1].acc_sat
                        | flag_ff[VTPD_DIV_LAT-1].wz | (|div_sat);

endmodule

`default_nettype wire

[rtl/vtpd_col.sv]
// ----------------------------------------------------------------------------
// vtpd_col
// One matrix column: three products, floor shift, sum with translation,
// clamp to the 48-bit accumulator. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_col
   import vtpd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  vtpd_elem_type x_in,
   input  vtpd_elem_type y_in,
   input  vtpd_elem_type z_in,
   input  vtpd_elem_type m0,
   input  vtpd_elem_type m1,
   input  vtpd_elem_type m2,
   input  vtpd_elem_type t,
   output logic          out_valid,
   output vtpd_acc_type  h,
   output logic          sat
);

   localparam int SUM_W = 2 * VTPD_ELEM_W + 2;
   localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(48'sh7FFF_FFFF_FFFF);
   localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

   logic signed [2*VTPD_ELEM_W-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [2*VTPD_ELEM_W-1:0] p0_in, p1_in, p2_in;
   vtpd_elem_type                   t_ff;
   logic                            vld1_ff, vld2_ff;
   logic signed [SUM_W-1:0]         sum;
   vtpd_acc_type                    h_ff, h_in;
   logic                            sat_ff, sat_in;

   always_comb begin
      p0_in = x_in * m0;
      p1_in = y_in * m1;
      p2_in = z_in * m2;
   end

   // floor shift is the arithmetic shift
   always_comb begin
      sum = SUM_W'(p0_ff >>> FRAC_BITS) + SUM_W'(p1_ff >>> FRAC_BITS)
          + SUM_W'(p2_ff >>> FRAC_BITS) + SUM_W'(t_ff);
      sat_in = 1'b0;
      if (sum > ACC_MAX) begin
         h_in   = ACC_MAX[VTPD_ACC_W-1:0];
         sat_in = 1'b1;
      end else if (sum < ACC_MIN) begin
         h_in   = ACC_MIN[VTPD_ACC_W-1:0];
         sat_in = 1'b1;
      end else begin
         h_in = sum[VTPD_ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      t_ff   <= t;
      h_ff   <= h_in;
      sat_ff <= sat_in;
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   assign out_valid = vld2_ff;
   assign h         = h_ff;
   assign sat       = sat_ff;

endmodule

`default_nettype wire

[rtl/vtpd_div.sv]
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider: n * 2^FRAC_BITS / w toward zero, clamped to
// 32-bit signed, one quotient bit per stage. Zero w gives the numerator sign.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_div
   import vtpd_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  vtpd_acc_type  num,
   input  vtpd_acc_type  den,
   output logic          out_valid,
   output vtpd_elem_type quo,
   output logic          sat
);

   localparam int DND_W = VTPD_ACC_W + FRAC_BITS;
   localparam int HI_W  = DND_W - VTPD_QUO_W;

   vtpd_div_stage_type              st_ff [0:VTPD_QUO_W];
   vtpd_div_stage_type              st_in [0:VTPD_QUO_W];
   logic [VTPD_ACC_W-1:0]           an, aw;
   logic [DND_W-1:0]                dfull;
   logic [HI_W-1:0]                 dhi;
   vtpd_elem_type                   quo_ff, quo_in;
   logic                            sat_ff, sat_in, vld_ff;
   logic                            big;
   vtpd_div_stage_type              last;

   // entry: magnitudes, signs, overflow test on the upper dividend bits
   always_comb begin
      an    = num[VTPD_ACC_W-1] ? VTPD_ACC_W'(-num) : VTPD_ACC_W'(num);
      aw    = den[VTPD_ACC_W-1] ? VTPD_ACC_W'(-den) : VTPD_ACC_W'(den);
      dfull = {an, {FRAC_BITS{1'b0}}};
      dhi   = dfull[DND_W-1:VTPD_QUO_W];
      st_in[0].vld  = in_valid;
      st_in[0].rem  = VTPD_ACC_W'(dhi);
      st_in[0].dvs  = aw;
      st_in[0].dnd  = dfull[VTPD_QUO_W-1:0];
      st_in[0].quo  = '0;
      st_in[0].neg  = num[VTPD_ACC_W-1] ^ den[VTPD_ACC_W-1];
      st_in[0].ovf  = VTPD_ACC_W'(dhi) >= aw;
      st_in[0].wz   = (den == '0);
      st_in[0].npos = !num[VTPD_ACC_W-1] && (num != '0);
      st_in[0].nneg = num[VTPD_ACC_W-1];
   end

   for (genvar k = 0; k < VTPD_QUO_W; k++) begin : g_bit
      logic [VTPD_ACC_W:0] trial;
      logic                ge;
      always_comb begin
         trial        = {st_ff[k].rem, st_ff[k].dnd[VTPD_QUO_W-1]};
         ge           = trial >= {1'b0, st_ff[k].dvs};
         st_in[k+1]     = st_ff[k];
         st_in[k+1].rem = ge ? VTPD_ACC_W'(trial - {1'b0, st_ff[k].dvs})
                             : trial[VTPD_ACC_W-1:0];
         st_in[k+1].dnd = {st_ff[k].dnd[VTPD_QUO_W-2:0], 1'b0};
         st_in[k+1].quo = {st_ff[k].quo[VTPD_QUO_W-2:0], ge};
      end
   end

   for (genvar k = 0; k <= VTPD_QUO_W; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k] <= '0;
         end else begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // output: sign, clamp, zero-w handling
   always_comb begin
      last   = st_ff[VTPD_QUO_W];
      big    = last.ovf || (last.quo[VTPD_QUO_W-1] &&
               (!last.neg || (last.quo[VTPD_QUO_W-2:0] != '0)));
      sat_in = 1'b0;
      if (last.wz) begin
         if (last.npos) begin
            quo_in = VTPD_OUT_MAX;
         end else if (last.nneg) begin
            quo_in = VTPD_OUT_MIN;
         end else begin
            quo_in = '0;
         end
      end else if (big) begin
         sat_in = 1'b1;
         quo_in = last.neg ? VTPD_OUT_MIN : VTPD_OUT_MAX;
      end else begin
         quo_in = last.neg ? -vtpd_elem_type'(last.quo) : vtpd_elem_type'(last.quo);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      sat_ff <= sat_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= last.vld;
      end
   end

   assign out_valid = vld_ff;
   assign quo       = quo_ff;
   assign sat       = sat_ff;

endmodule

`default_nettype wire

[rtl/vtpd_checker.sv]
// ----------------------------------------------------------------------------
// vtpd_checker
// Port-level checks of the vertex transform block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vertex_transform_perspective_divide_macros.svh"

module vtpd_checker
   import vtpd_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input logic          rsp_valid,
   input vtpd_elem_type rsp_x_out,
   input logic          rsp_w_zero,
   input logic          rsp_saturated
);

   `VTPD_ASSERT_IMPL(a_wz_sat, clock, reset, rsp_valid && rsp_w_zero, rsp_saturated, "w_zero without saturated")
   `VTPD_ASSERT_IMPL(a_wz_x, clock, reset, rsp_valid && rsp_w_zero, (rsp_x_out == VTPD_OUT_MAX) || (rsp_x_out == VTPD_OUT_MIN) || (rsp_x_out == '0), "zero w gave an unsaturated x")
   `VTPD_ASSERT_IMPL(a_no_orphan, clock, reset, rsp_valid, $past(start && !busy, VTPD_LATENCY), "result beat without a request beat")
   `VTPD_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid, "result beat right after reset")

endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (.*);

`default_nettype wire
